### hw/rtl/lsmt_pkg.sv
// ----------------------------------------------------------------------------
// lsmt_pkg
// Shared types and constants for the linear sieve table engine.
// ----------------------------------------------------------------------------
package lsmt_pkg;

  localparam int unsigned MaxLimit   = 65536;
  localparam int unsigned PrimeDepth = 8192;
  localparam int unsigned IdxW       = $clog2(MaxLimit + 1);
  localparam int unsigned PIdxW      = $clog2(PrimeDepth);
  localparam int unsigned PCntW      = $clog2(PrimeDepth + 1);
  localparam int unsigned TotW       = 14;
  localparam logic [TotW-1:0] TotMax = '1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StRange    = 2'd1,
    StNotBuilt = 2'd2
  } status_e;

  typedef enum logic {
    OpBuild = 1'b0,
    OpQuery = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    SIdle,
    SClear,
    SRdI,
    SGotI,
    SRdP,
    SGotP,
    SCross,
    SQuery
  } state_e;

  // one table row: mark, smallest prime factor, phi, mu, divisors,
  // divisors of the cofactor without the smallest prime, its exponent
  typedef struct packed {
    logic            comp;
    logic [IdxW-1:0] lpf;
    logic [IdxW-1:0] phi;
    logic [1:0]      mu;
    logic [7:0]      dc;
    logic [7:0]      rc;
    logic [4:0]      ex;
  } lsmt_entry_t;

endpackage

### hw/rtl/linear_sieve_multiplicative_tables.sv
// ----------------------------------------------------------------------------
// linear_sieve_multiplicative_tables
// Linear sieve over 1..limit filling phi, mu and divisor count tables.
// ----------------------------------------------------------------------------
// Query: on an error the result strobe rises in the cycle after start; a table
//   read passes one table memory read and one output register while busy.
// Build: clears entries 1..limit, then per integer SRdI, SGotI, SRdP and per
//   crossing-out SGotP, SCross on the table memory; result after the walk.
// Reset clears control state and sets the limit to 65536; tables are invalid
//   until the first build. The receiver cannot stall; each result is one beat.
module linear_sieve_multiplicative_tables
  import lsmt_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   op_i,
  input  logic [IdxW-1:0]        query_index_i,
  input  logic                   cfg_we_i,
  input  logic [IdxW-1:0]        cfg_wdata_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic                   is_prime_o,
  output logic [IdxW-1:0]        totient_o,
  output logic signed [1:0]      mobius_o,
  output logic [7:0]             divisor_count_o,
  output logic [TotW-1:0]        primes_found_o
);

  state_e state_q, state_d;

  // configuration and build bookkeeping
  logic [IdxW-1:0]  limit_q, lim_q, built_q, i_q;
  logic             valid_q;
  logic [TotW-1:0]  total_q;
  logic [PCntW-1:0] stored_q, j_q;

  // walk datapath
  lsmt_entry_t      ent_q, x_q;
  logic [2*IdxW-1:0] m_q;
  logic             div_q;

  // result beat
  logic             done_q, prime_q;
  status_e          status_q;
  logic [IdxW-1:0]  phi_q;
  logic [1:0]       mu_q;
  logic [7:0]       dc_q;

  // table memory
  lsmt_entry_t      tbl_mem [MaxLimit+1];
  lsmt_entry_t      tbl_rdata_q, tbl_wdata;
  logic             tbl_we;
  logic [IdxW-1:0]  tbl_waddr, tbl_raddr;

  // prime list memory
  logic [IdxW-1:0]  pl_mem [PrimeDepth];
  logic [IdxW-1:0]  pl_rdata_q;
  logic             pl_we;

  logic             accept, next_i, finish;
  logic [IdxW-1:0]  lim_clamped;

  // walk products, registered in SGotP
  logic [IdxW-1:0]   p_w;
  logic [2*IdxW-1:0] m_w, phi_w;
  logic [13:0]       rc_w;
  logic              div_w;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != SIdle);

  always_comb begin
    if (limit_q == '0) begin
      lim_clamped = IdxW'(1);
    end else if (limit_q > IdxW'(MaxLimit)) begin
      lim_clamped = IdxW'(MaxLimit);
    end else begin
      lim_clamped = limit_q;
    end
  end

  // prime p divides i exactly when it is i's smallest prime factor
  assign p_w   = pl_rdata_q;
  assign div_w = (p_w == ent_q.lpf);
  assign m_w   = (2*IdxW)'(i_q) * (2*IdxW)'(p_w);
  assign phi_w = (2*IdxW)'(ent_q.phi) * (2*IdxW)'(div_w ? p_w : p_w - IdxW'(1));
  assign rc_w  = 14'(ent_q.rc) * 14'({1'b0, ent_q.ex} + 6'd2);

  // ---------------- next state and memory control ----------------
  always_comb begin
    state_d   = state_q;
    tbl_we    = 1'b0;
    tbl_waddr = i_q;
    tbl_wdata = '0;
    tbl_raddr = i_q;
    pl_we     = 1'b0;
    next_i    = 1'b0;
    finish    = 1'b0;
    case (state_q)
      SIdle: begin
        tbl_raddr = query_index_i;
        if (accept) begin
          if (op_i == OpBuild) begin
            state_d = SClear;
          end else if (valid_q && query_index_i != '0 && query_index_i <= built_q) begin
            state_d = SQuery;
          end
        end
      end
      SClear: begin
        tbl_we = 1'b1;
        if (i_q == IdxW'(1)) begin
          tbl_wdata = '{comp: 1'b1, lpf: '0, phi: IdxW'(1), mu: 2'b01,
                        dc: 8'd1, rc: 8'd1, ex: 5'd0};
        end
        if (i_q == lim_q) begin
          if (lim_q == IdxW'(1)) begin
            finish  = 1'b1;
            state_d = SIdle;
          end else begin
            state_d = SRdI;
          end
        end
      end
      SRdI: begin
        state_d = SGotI;
      end
      SGotI: begin
        if (!tbl_rdata_q.comp) begin
          tbl_we    = 1'b1;
          tbl_wdata = '{comp: 1'b0, lpf: i_q, phi: i_q - IdxW'(1), mu: 2'b11,
                        dc: 8'd2, rc: 8'd1, ex: 5'd1};
          pl_we     = (stored_q < PCntW'(PrimeDepth));
        end
        state_d = SRdP;
      end
      SRdP: begin
        if (j_q == stored_q) begin
          next_i = 1'b1;
        end else begin
          state_d = SGotP;
        end
      end
      SGotP: begin
        state_d = SCross;
      end
      SCross: begin
        if (m_q > (2*IdxW)'(lim_q)) begin
          next_i = 1'b1;
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = m_q[IdxW-1:0];
          tbl_wdata = x_q;
          if (div_q) begin
            next_i = 1'b1;
          end else begin
            state_d = SRdP;
          end
        end
      end
      SQuery: begin
        state_d = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    if (next_i) begin
      if (i_q == lim_q) begin
        finish  = 1'b1;
        state_d = SIdle;
      end else begin
        state_d = SRdI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      pl_mem[stored_q[PIdxW-1:0]] <= i_q;
    end
    pl_rdata_q <= pl_mem[j_q[PIdxW-1:0]];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= IdxW'(MaxLimit);
      lim_q    <= '0;
      built_q  <= '0;
      valid_q  <= 1'b0;
      total_q  <= '0;
      stored_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      done_q   <= 1'b0;
      status_q <= StOk;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      done_q <= 1'b0;
      if (accept) begin
        status_q <= StOk;
        if (op_i == OpBuild) begin
          lim_q    <= lim_clamped;
          total_q  <= '0;
          stored_q <= '0;
          i_q      <= IdxW'(1);
        end else if (!valid_q) begin
          status_q <= StNotBuilt;
          done_q   <= 1'b1;
        end else if (query_index_i == '0 || query_index_i > built_q) begin
          status_q <= StRange;
          done_q   <= 1'b1;
        end
      end
      case (state_q)
        SClear: begin
          if (i_q == lim_q) begin
            i_q <= IdxW'(2);
          end else begin
            i_q <= i_q + IdxW'(1);
          end
        end
        SGotI: begin
          j_q <= '0;
          if (!tbl_rdata_q.comp) begin
            if (total_q != TotMax) begin
              total_q <= total_q + TotW'(1);
            end
            if (pl_we) begin
              stored_q <= stored_q + PCntW'(1);
            end
          end
        end
        SCross: begin
          if (!next_i) begin
            j_q <= j_q + PCntW'(1);
          end
        end
        SQuery: begin
          done_q <= 1'b1;
        end
        default: ;
      endcase
      if (next_i && !finish) begin
        i_q <= i_q + IdxW'(1);
      end
      if (finish) begin
        built_q <= lim_q;
        valid_q <= 1'b1;
        done_q  <= 1'b1;
      end
    end
  end

  // ---------------- walk and result payload ----------------
  always_ff @(posedge clk_i) begin
    if (state_q == SGotI) begin
      if (!tbl_rdata_q.comp) begin
        ent_q <= '{comp: 1'b0, lpf: i_q, phi: i_q - IdxW'(1), mu: 2'b11,
                   dc: 8'd2, rc: 8'd1, ex: 5'd1};
      end else begin
        ent_q <= tbl_rdata_q;
      end
    end
    if (state_q == SGotP) begin
      m_q      <= m_w;
      div_q    <= div_w;
      x_q.comp <= 1'b1;
      x_q.lpf  <= p_w;
      x_q.phi  <= phi_w[IdxW-1:0];
      if (div_w) begin
        x_q.mu <= 2'b00;
        x_q.dc <= rc_w[7:0];
        x_q.rc <= ent_q.rc;
        x_q.ex <= ent_q.ex + 5'd1;
      end else begin
        x_q.mu <= 2'(-ent_q.mu);
        x_q.dc <= {ent_q.dc[6:0], 1'b0};
        x_q.rc <= ent_q.dc;
        x_q.ex <= 5'd1;
      end
    end
    if (state_q == SQuery) begin
      prime_q <= !tbl_rdata_q.comp;
      phi_q   <= tbl_rdata_q.phi;
      mu_q    <= tbl_rdata_q.mu;
      dc_q    <= tbl_rdata_q.dc;
    end else if (state_q == SIdle || finish) begin
      prime_q <= 1'b0;
      phi_q   <= '0;
      mu_q    <= '0;
      dc_q    <= '0;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign is_prime_o      = prime_q;
  assign totient_o       = phi_q;
  assign mobius_o        = mu_q;
  assign divisor_count_o = dc_q;
  assign primes_found_o  = total_q;

  // ---------------- assertions ----------------
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == SIdle)
    else $error("result beat while busy");

  a_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(valid_q) |-> valid_q)
    else $error("tables valid dropped");

  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= PCntW'(PrimeDepth))
    else $error("prime list overrun");

  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SRdI || state_q == SGotI) |-> (i_q >= IdxW'(2) && i_q <= lim_q))
    else $error("walk index outside limit");

endmodule
